// ===== rtl/kbq_pkg.sv =====
package kbq_pkg;

  // Command codes carried in s_tuser
  localparam logic [1:0] CMD_KEY     = 2'd0;
  localparam logic [1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // Code, scancode and queue count widths
  localparam int CODE_W  = 9;
  localparam int SCAN_W  = 17;
  localparam int COUNT_W = 4;

  // Control for one queue cell
  typedef struct packed {
    logic load;   // take the incoming code
    logic shift;  // take the neighbor's code (queue moves toward the head)
  } cell_ctrl_t;

endpackage

// ===== rtl/keyboard_event_queue_controller.sv =====
// Keyboard event queue controller. Each transaction on the s_ side carries
// one command in s_tuser (key event, dequeue, clear ready) and produces
// exactly one registered result on the m_ side: the scancode latch, the
// ready flag, the interrupt pulse, the queue count and the drop flag. A
// command is decoded combinationally, so one transaction per cycle is
// sustained; the only limit is the single output register, which accepts a
// new command while its result is being taken. Queued codes live in a chain
// of QUEUE_DEPTH cells that shifts toward the head on a dequeue. The
// interrupt enable is written through cfg_valid/cfg_data, always ready.
module keyboard_event_queue_controller #(
  parameter int QUEUE_DEPTH = 10
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] key_code, [8] key_down, [15:9] zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [16:0] scancode, [17] ready_res,
                                 // [18] interrupt_request, [22:19] queue_count,
                                 // [23] dropped
  // Configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data   // interrupt_enable
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int CODE_W = kbq_pkg::CODE_W;
  localparam int SCAN_W = kbq_pkg::SCAN_W;

  logic              ien;
  logic              ready_flag, ready_flag_next;
  logic [SCAN_W-1:0] latch, latch_next;
  logic [CW-1:0]     count, count_next;
  logic              irq, drop, push, pop, accept;
  logic [CODE_W-1:0] code_in;
  logic [CODE_W-1:0] cell_code [QUEUE_DEPTH];
  logic [1:0]        command;

  assign accept    = s_tvalid & s_tready;
  assign s_tready  = ~m_tvalid | m_tready;
  assign cfg_ready = 1'b1;
  assign command   = s_tuser;
  assign code_in   = {~s_tdata[8], s_tdata[7:0]};

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ien <= 1'b0;
    end else if (cfg_valid) begin
      ien <= cfg_data;
    end
  end

  // Command decode and next state
  always_comb begin
    ready_flag_next = ready_flag;
    latch_next      = latch;
    count_next      = count;
    irq             = 1'b0;
    drop            = 1'b0;
    push            = 1'b0;
    pop             = 1'b0;
    case (command)
      kbq_pkg::CMD_KEY: begin
        if (!ready_flag) begin
          latch_next = {1'b1, 7'd0, code_in};
          if (ien) begin
            ready_flag_next = 1'b1;
            irq             = 1'b1;
          end
        end else if (count < CW'(QUEUE_DEPTH)) begin
          push       = 1'b1;
          count_next = count + CW'(1);
        end else begin
          drop = 1'b1;
        end
      end
      kbq_pkg::CMD_DEQUEUE: begin
        if (!ready_flag && count != '0) begin
          pop        = 1'b1;
          count_next = count - CW'(1);
          latch_next = {1'b1, 7'd0, cell_code[0]};
          if (ien) begin
            ready_flag_next = 1'b1;
            irq             = 1'b1;
          end
        end
      end
      kbq_pkg::CMD_CLEAR: begin
        ready_flag_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Chain of queue cells
  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      kbq_pkg::cell_ctrl_t ctrl;
      logic [CODE_W-1:0]   neighbor;
      assign ctrl.shift = accept & pop;
      assign ctrl.load  = accept & push & (count == CW'(i));
      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign neighbor = '0;
      end else begin : g_mid
        assign neighbor = cell_code[i+1];
      end
      kbq_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .code_in  (code_in),
        .neighbor (neighbor),
        .code     (cell_code[i])
      );
    end
  endgenerate

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_flag <= 1'b0;
      latch      <= '0;
      count      <= '0;
    end else if (accept) begin
      ready_flag <= ready_flag_next;
      latch      <= latch_next;
      count      <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {drop, kbq_pkg::COUNT_W'(count_next), irq, ready_flag_next, latch_next};
    end
  end

`ifndef NO_ASSERTIONS
  // Queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // Ready only rises while interrupts were enabled
  a_ready_ien: assert property (@(posedge clk) disable iff (rst)
    $rose(ready_flag) |-> $past(ien))
    else $error("ready set with interrupts disabled");

  // A key event into a full queue while ready reports a drop
  a_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && command == kbq_pkg::CMD_KEY && ready_flag && count == CW'(QUEUE_DEPTH))
    |=> (m_tvalid && m_tdata[23]))
    else $error("missing drop flag");

  // An interrupt pulse always comes with the ready flag set
  a_irq_ready: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[18]) |-> m_tdata[17])
    else $error("interrupt without ready");
`endif

endmodule

// ===== rtl/kbq_cell.sv =====
// One queue entry. Cell 0 is the head; a pop shifts every cell one place
// toward the head, a push loads the first free cell.
module kbq_cell (
  input  logic                       clk,
  input  kbq_pkg::cell_ctrl_t        ctrl,
  input  logic [kbq_pkg::CODE_W-1:0] code_in,
  input  logic [kbq_pkg::CODE_W-1:0] neighbor,
  output logic [kbq_pkg::CODE_W-1:0] code
);

  // Payload only; occupancy is tracked by the controller count
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      code <= neighbor;
    end else if (ctrl.load) begin
      code <= code_in;
    end
  end

endmodule

// ===== test/keyboard_event_queue_controller_test.sv =====
module keyboard_event_queue_controller_test;

  localparam int QUEUE_DEPTH = 10;
  // Command code that the block treats as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_GAP = 8;

  // One result, laid out as on m_tdata (first member is the top bit)
  typedef struct packed {
    logic                        dropped;
    logic [kbq_pkg::COUNT_W-1:0] queue_count;
    logic                        irq;
    logic                        ready;
    logic [kbq_pkg::SCAN_W-1:0]  scancode;
  } kb_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [7:0] key_code, [8] key_down, [15:9] zero
  logic [1:0]  s_tuser;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [16:0] scancode, [17] ready_res, [18] interrupt_request,
                          // [22:19] queue_count, [23] dropped
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;  // interrupt_enable

  keyboard_event_queue_controller #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Shadow of the controller state
  logic [kbq_pkg::CODE_W-1:0] queue_mem [QUEUE_DEPTH];
  int unsigned                wr_ptr = 0;
  int unsigned                rd_ptr = 0;
  int unsigned                held_count = 0;
  bit                         ready_model = 0;
  logic [kbq_pkg::SCAN_W-1:0] latch_model = '0;
  bit                         irq_en_model = 0;

  kb_result_t pending_results[$];

  int mismatch_count = 0;
  int commands_sent = 0;
  int results_checked = 0;
  int drops_seen = 0;
  int irqs_seen = 0;

  // Idling control shared by the stimulus and the receiver
  bit tx_fast = 0;
  bit rx_fast = 0;
  int rx_hold = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Latch a code as a valid scancode; returns the interrupt pulse
  function automatic bit load_latch(logic [kbq_pkg::CODE_W-1:0] code);
    latch_model = {1'b1, 7'b0, code};
    if (irq_en_model) begin
      ready_model = 1;
      return 1;
    end
    return 0;
  endfunction

  // Advance the shadow state by one command and return its result
  function automatic kb_result_t predict_result(logic [1:0] cmd, logic [7:0] key,
                                                logic down);
    kb_result_t                 r;
    logic [kbq_pkg::CODE_W-1:0] code;
    r = '0;
    case (cmd)
      kbq_pkg::CMD_KEY: begin
        code = {~down, key};
        if (!ready_model) begin
          r.irq = load_latch(code);
        end else if (held_count < QUEUE_DEPTH) begin
          queue_mem[wr_ptr] = code;
          wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
          held_count++;
        end else begin
          r.dropped = 1;
        end
      end
      kbq_pkg::CMD_DEQUEUE: begin
        if (!ready_model && held_count > 0) begin
          code = queue_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
          held_count--;
          r.irq = load_latch(code);
        end
      end
      kbq_pkg::CMD_CLEAR: begin
        ready_model = 0;
      end
      default: ;
    endcase
    r.scancode = latch_model;
    r.ready = ready_model;
    r.queue_count = held_count[kbq_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // Monitor: check results, then track config and input transactions
  always @(posedge clk) begin
    kb_result_t got;
    kb_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_results.size() == 0) begin
          report_error($sformatf("result %0h with no command outstanding", m_tdata));
        end else begin
          want = pending_results.pop_front();
          if (got.scancode !== want.scancode)
            report_error($sformatf("scancode got %0h expected %0h",
                                   got.scancode, want.scancode));
          if (got.ready !== want.ready)
            report_error($sformatf("ready_res got %0b expected %0b", got.ready, want.ready));
          if (got.irq !== want.irq)
            report_error($sformatf("interrupt_request got %0b expected %0b",
                                   got.irq, want.irq));
          if (got.queue_count !== want.queue_count)
            report_error($sformatf("queue_count got %0d expected %0d",
                                   got.queue_count, want.queue_count));
          if (got.dropped !== want.dropped)
            report_error($sformatf("dropped got %0b expected %0b",
                                   got.dropped, want.dropped));
          results_checked++;
          if (want.dropped) drops_seen++;
          if (want.irq) irqs_seen++;
        end
      end
      if (cfg_valid && cfg_ready) irq_en_model = cfg_data;
      if (s_tvalid && s_tready) begin
        pending_results.push_back(predict_result(s_tuser, s_tdata[7:0], s_tdata[8]));
        commands_sent++;
      end
    end
  end

  // Receiver: random stalls per result, with an optional long hold-off
  initial begin
    int gap;
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready <= 0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end
      gap = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Offer one command; called and returns at a falling edge, valid left high
  task automatic send_item(logic [1:0] cmd, logic [7:0] key, logic down);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= cmd;
    s_tdata  <= {7'b0, down, key};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Drop valid and let every outstanding result arrive
  task automatic wait_idle();
    s_tvalid <= 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_irq_enable(bit value);
    cfg_valid <= 1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Weighted random command with random payload
  task automatic send_random(int key_pct, int deq_pct, int clr_pct);
    int          pick;
    logic [1:0]  cmd;
    pick = $urandom_range(0, 99);
    if (pick < key_pct) cmd = kbq_pkg::CMD_KEY;
    else if (pick < key_pct + deq_pct) cmd = kbq_pkg::CMD_DEQUEUE;
    else if (pick < key_pct + deq_pct + clr_pct) cmd = kbq_pkg::CMD_CLEAR;
    else cmd = CMD_UNUSED;
    send_item(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Extremes, every command, full queue, drops, interrupts off and on
  task automatic test_directed();
    // Interrupts off after reset: latch is overwritten, ready stays clear
    send_item(kbq_pkg::CMD_KEY, 8'h00, 1'b1);
    send_item(kbq_pkg::CMD_KEY, 8'hFF, 1'b0);
    send_item(kbq_pkg::CMD_DEQUEUE, 8'h00, 1'b0);
    send_item(kbq_pkg::CMD_CLEAR, 8'hFF, 1'b1);
    send_item(CMD_UNUSED, 8'hA5, 1'b1);
    wait_idle();
    // Interrupts on: latch, then fill the queue past its depth
    write_irq_enable(1);
    send_item(kbq_pkg::CMD_KEY, 8'h80, 1'b1);
    for (int i = 0; i <= QUEUE_DEPTH; i++)
      send_item(kbq_pkg::CMD_KEY, (i % 2) ? 8'hFF : 8'(i), 1'(i % 2));
    send_item(kbq_pkg::CMD_DEQUEUE, 8'h00, 1'b0);   // blocked while ready
    send_item(kbq_pkg::CMD_CLEAR, 8'h00, 1'b0);
    send_item(kbq_pkg::CMD_DEQUEUE, 8'hFF, 1'b1);
    send_item(CMD_UNUSED, 8'h5A, 1'b0);
    wait_idle();
    // Interrupts off with codes still queued: pops land without ready
    write_irq_enable(0);
    send_item(kbq_pkg::CMD_CLEAR, 8'h00, 1'b0);
    send_item(kbq_pkg::CMD_DEQUEUE, 8'h00, 1'b0);
    send_item(kbq_pkg::CMD_DEQUEUE, 8'h00, 1'b0);
    wait_idle();
  endtask

  // Random phases over both enable settings, fill-heavy and drain-heavy
  task automatic test_random_phases();
    write_irq_enable(1);
    repeat (200) send_random(50, 25, 20);
    wait_idle();
    write_irq_enable(0);
    repeat (150) send_random(50, 30, 15);
    wait_idle();
    write_irq_enable(1);
    repeat (200) send_random(75, 10, 12);
    wait_idle();
    write_irq_enable(1);
    repeat (150) send_random(30, 35, 30);
    wait_idle();
  endtask

  // No idling on either side
  task automatic test_back_to_back();
    tx_fast = 1;
    rx_fast = 1;
    repeat (60) send_random(50, 25, 20);
    wait_idle();
    tx_fast = 0;
    rx_fast = 0;
  endtask

  // Receiver holds off while commands keep coming, so the input stalls
  task automatic test_output_stall();
    write_irq_enable(1);
    tx_fast = 1;
    rx_hold = 80;
    repeat (40) send_random(60, 20, 15);
    wait_idle();
    tx_fast = 0;
    write_irq_enable(0);
    repeat (40) send_random(50, 25, 20);
    wait_idle();
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = kbq_pkg::CMD_KEY;
    cfg_valid = 0;
    cfg_data = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    test_directed();
    test_random_phases();
    test_back_to_back();
    test_output_stall();

    $display("Ran %0d commands and checked %0d results across both interrupt settings,",
             commands_sent, results_checked);
    $display("with %0d dropped key events, %0d interrupts and one long output stall.",
             drops_seen, irqs_seen);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
